/* design/i2cbm_pkg.sv */
// Package for the byte-level I2C master: command codes, status codes and sequencer phases.
package i2cbm_pkg;

    localparam int unsigned TickWidth = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned BitCntWidth = 4;
    localparam logic [TickWidth-1:0] PhaseTicksReset = 16'd1;
    localparam logic [BitCntWidth-1:0] BitsPerByte = 4'd8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_PASS    = 2'd0,
        STATUS_NACK    = 2'd1,
        STATUS_CLK_LOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_WR_LOW   = 4'd3,
        PH_WR_HIGH  = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_HIGH = 4'd6,
        PH_RD_HIGH  = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_WA_LOW   = 4'd9,
        PH_WA_HIGH  = 4'd10,
        PH_STOP_A   = 4'd11,
        PH_STOP_B   = 4'd12,
        PH_STOP_C   = 4'd13
    } phase_t;

endpackage

/* design/i2c_byte_master.sv */
// Top level of the byte-level open-drain I2C master sequencer.
//
// Each input beat is one tick of bus time. A beat carries an optional command
// (start with address, write byte, read byte, stop) and the sampled SDA and SCL
// levels; it yields one result beat with the SCL and SDA release levels, busy,
// done, status and the last received byte. Every half-phase of SCL lasts
// phase_ticks ticks (zero acts as one), set through cfg_we/cfg_data while the
// block is idle: the user's duty, not enforced. The sequencer state is updated
// in the cycle a beat is accepted and the result lands in an output register,
// so the block takes one beat per clock cycle and the result appears in the next
// cycle. The only limit is the output register: in_ready drops only while a
// result waits on a low out_ready. Commands arriving while busy, or on the tick
// a command ends, are ignored. A start with SCL low ends at once with status 2.
module i2c_byte_master
    import i2cbm_pkg::*;
#(
    parameter logic [i2cbm_pkg::TickWidth-1:0] PHASE_TICKS_RESET = i2cbm_pkg::PhaseTicksReset
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [i2cbm_pkg::TickWidth-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd_valid,
    input  logic [1:0]                        operation,
    input  logic [i2cbm_pkg::ByteWidth-1:0]   tx_byte,
    input  logic                              send_nack,
    input  logic                              sda_in,
    input  logic                              scl_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              scl_release,
    output logic                              sda_release,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [1:0]                        status,
    output logic [i2cbm_pkg::ByteWidth-1:0]   rx_byte
);

    // Sequencer state.
    logic [TickWidth-1:0]   phase_ticks_reg;
    phase_t                 phase_reg, phase_next;
    logic [BitCntWidth-1:0] bit_count_reg, bit_count_next;
    logic [ByteWidth-1:0]   shift_reg, shift_next;
    logic [TickWidth-1:0]   tick_count_reg, tick_count_next;
    logic                   nack_flag_reg, nack_flag_next;
    status_t                last_status_reg, last_status_next;
    logic [ByteWidth-1:0]   rx_hold_reg, rx_hold_next;
    logic                   line_scl_reg, line_scl_next;
    logic                   line_sda_reg, line_sda_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   res_scl_reg, res_sda_reg, res_busy_reg, res_done_reg;
    status_t                res_status_reg;
    logic [ByteWidth-1:0]   res_rx_reg;

    logic                   accept;
    logic                   done_next;
    logic                   enter_en;
    phase_t                 enter_phase;
    logic [TickWidth-1:0]   limit;
    logic [TickWidth-1:0]   tick_inc;
    logic [BitCntWidth-1:0] bit_inc;

    // The output register frees up when its beat is taken, so a new beat can
    // enter in the same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign limit    = (phase_ticks_reg == '0) ? {{(TickWidth-1){1'b0}}, 1'b1} : phase_ticks_reg;
    assign tick_inc = tick_count_reg + {{(TickWidth-1){1'b0}}, 1'b1};
    assign bit_inc  = bit_count_reg + {{(BitCntWidth-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        tick_count_next  = tick_count_reg;
        nack_flag_next   = nack_flag_reg;
        last_status_next = last_status_reg;
        rx_hold_next     = rx_hold_reg;
        line_scl_next    = line_scl_reg;
        line_sda_next    = line_sda_reg;
        done_next        = 1'b0;
        enter_en         = 1'b0;
        enter_phase      = PH_IDLE;

        if (phase_reg == PH_IDLE)
        begin
            if (cmd_valid)
            begin
                bit_count_next = '0;
                case (op_t'(operation))
                    OP_START:
                    begin
                        if (!scl_in)
                        begin
                            last_status_next = STATUS_CLK_LOW;
                            done_next        = 1'b1;
                        end
                        else
                        begin
                            shift_next  = tx_byte;
                            enter_en    = 1'b1;
                            enter_phase = PH_START_A;
                        end
                    end
                    OP_WRITE:
                    begin
                        shift_next  = tx_byte;
                        enter_en    = 1'b1;
                        enter_phase = PH_WR_LOW;
                    end
                    OP_READ:
                    begin
                        shift_next     = '0;
                        nack_flag_next = send_nack;
                        enter_en       = 1'b1;
                        enter_phase    = PH_RD_HIGH;
                    end
                    default:
                    begin
                        enter_en    = 1'b1;
                        enter_phase = PH_STOP_A;
                    end
                endcase
            end
        end
        else if (tick_inc >= limit)
        begin
            tick_count_next = '0;
            case (phase_reg)
                PH_START_A:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_START_B;
                end
                PH_START_B:
                begin
                    bit_count_next = '0;
                    enter_en       = 1'b1;
                    enter_phase    = PH_WR_LOW;
                end
                PH_WR_LOW:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_WR_HIGH;
                end
                PH_WR_HIGH:
                begin
                    shift_next     = {shift_reg[ByteWidth-2:0], 1'b0};
                    bit_count_next = bit_inc;
                    enter_en       = 1'b1;
                    enter_phase    = (bit_inc >= BitsPerByte) ? PH_ACK_LOW : PH_WR_LOW;
                end
                PH_ACK_LOW:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH:
                begin
                    nack_flag_next   = sda_in;
                    last_status_next = sda_in ? STATUS_NACK : STATUS_PASS;
                    line_scl_next    = 1'b0;
                    phase_next       = PH_IDLE;
                    done_next        = 1'b1;
                end
                PH_RD_HIGH:
                begin
                    shift_next     = {shift_reg[ByteWidth-2:0], sda_in};
                    bit_count_next = bit_inc;
                    enter_en       = 1'b1;
                    enter_phase    = PH_RD_LOW;
                end
                PH_RD_LOW:
                begin
                    enter_en    = 1'b1;
                    enter_phase = (bit_count_reg >= BitsPerByte) ? PH_WA_LOW : PH_RD_HIGH;
                end
                PH_WA_LOW:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_WA_HIGH;
                end
                PH_WA_HIGH:
                begin
                    rx_hold_next     = shift_reg;
                    last_status_next = STATUS_PASS;
                    line_scl_next    = 1'b0;
                    phase_next       = PH_IDLE;
                    done_next        = 1'b1;
                end
                PH_STOP_A:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_STOP_B;
                end
                PH_STOP_B:
                begin
                    enter_en    = 1'b1;
                    enter_phase = PH_STOP_C;
                end
                PH_STOP_C:
                begin
                    last_status_next = STATUS_PASS;
                    phase_next       = PH_IDLE;
                    done_next        = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            endcase
        end
        else
        begin
            tick_count_next = tick_inc;
        end

        // Entering a phase restarts the tick count and sets that phase's line levels,
        // using the shift and NACK values already updated above.
        if (enter_en)
        begin
            phase_next      = enter_phase;
            tick_count_next = '0;
            case (enter_phase)
                PH_START_A:  line_sda_next = 1'b0;
                PH_START_B:  line_scl_next = 1'b0;
                PH_WR_LOW:
                begin
                    line_scl_next = 1'b0;
                    line_sda_next = shift_next[ByteWidth-1];
                end
                PH_WR_HIGH:  line_scl_next = 1'b1;
                PH_ACK_LOW:
                begin
                    line_scl_next = 1'b0;
                    line_sda_next = 1'b1;
                end
                PH_ACK_HIGH: line_scl_next = 1'b1;
                PH_RD_HIGH:
                begin
                    line_scl_next = 1'b1;
                    line_sda_next = 1'b1;
                end
                PH_RD_LOW:   line_scl_next = 1'b0;
                PH_WA_LOW:
                begin
                    line_scl_next = 1'b0;
                    line_sda_next = nack_flag_next;
                end
                PH_WA_HIGH:  line_scl_next = 1'b1;
                PH_STOP_A:   line_sda_next = 1'b0;
                PH_STOP_B:   line_scl_next = 1'b1;
                PH_STOP_C:   line_sda_next = 1'b1;
                default:     line_scl_next = line_scl_reg;
            endcase
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            phase_ticks_reg <= cfg_data;
        end
    end

    // Sequencer state advances by one tick per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            tick_count_reg  <= '0;
            nack_flag_reg   <= 1'b0;
            last_status_reg <= STATUS_PASS;
            rx_hold_reg     <= '0;
            line_scl_reg    <= 1'b1;
            line_sda_reg    <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            tick_count_reg  <= tick_count_next;
            nack_flag_reg   <= nack_flag_next;
            last_status_reg <= last_status_next;
            rx_hold_reg     <= rx_hold_next;
            line_scl_reg    <= line_scl_next;
            line_sda_reg    <= line_sda_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with the state just computed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_scl_reg    <= line_scl_next;
            res_sda_reg    <= line_sda_next;
            res_busy_reg   <= (phase_next != PH_IDLE);
            res_done_reg   <= done_next;
            res_status_reg <= last_status_next;
            res_rx_reg     <= rx_hold_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = res_scl_reg;
    assign sda_release = res_sda_reg;
    assign busy_res    = res_busy_reg;
    assign done_res    = res_done_reg;
    assign status      = res_status_reg;
    assign rx_byte     = res_rx_reg;

endmodule

/* design/i2cbm_checker.sv */
// Port-level checker for the byte-level I2C master, with its bind statement.
module i2cbm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_release,
    input logic       sda_release,
    input logic       busy_res,
    input logic       done_res,
    input logic [1:0] status,
    input logic [7:0] rx_byte
);

    // A result that is stalled keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scl_release) && $stable(sda_release)
        && $stable(busy_res) && $stable(done_res) && $stable(status) && $stable(rx_byte))
        else $error("stalled result changed");

    // Every accepted beat produces a result in the next cycle.
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // With the output register empty the input side is never blocked.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // A finishing tick is never also a busy tick.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while busy");

endmodule

bind i2c_byte_master i2cbm_checker u_i2cbm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_release (scl_release),
    .sda_release (sda_release),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .status      (status),
    .rx_byte     (rx_byte)
);
